@@ rtl/hmlc_pkg.sv @@
package hmlc_pkg;

  localparam int unsigned BIN_COUNT_DEF   = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned PIX_RANGE  = 256;
  localparam int unsigned BIN_OUT_W  = 8;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned THR_W      = 9;
  localparam int unsigned NUM_LEVELS = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned M_DATA_W   = 32;

  localparam logic [THR_W-1:0] THR_RESET [NUM_LEVELS] = '{
    9'd200, 9'd170, 9'd140, 9'd110, 9'd80
  };

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_EMIT
  } hmlc_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic load_out;
    logic clear_wr;
  } hmlc_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
    logic clear_done;
  } hmlc_stat_t;

endpackage

@@ rtl/hmlc_ctrl.sv @@
module hmlc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hmlc_pkg::hmlc_stat_t  stat_i,
  output hmlc_pkg::hmlc_cmd_t   cmd_o
);

  hmlc_pkg::hmlc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmlc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hmlc_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_done) begin
          state_d = hmlc_pkg::ST_IDLE;
        end
      end
      hmlc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = hmlc_pkg::ST_UPDATE;
        end
      end
      hmlc_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = stat_i.last ? hmlc_pkg::ST_EMIT : hmlc_pkg::ST_IDLE;
      end
      hmlc_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = hmlc_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = hmlc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/hmlc_datapath.sv @@
module hmlc_datapath #(
  parameter int unsigned BIN_COUNT   = hmlc_pkg::BIN_COUNT_DEF,
  parameter int unsigned COUNT_WIDTH = hmlc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hmlc_pkg::hmlc_cmd_t             cmd_i,
  output hmlc_pkg::hmlc_stat_t            stat_o,
  input  logic [hmlc_pkg::PIX_W-1:0]      pixel_value_i,
  input  logic                            last_pixel_i,
  input  logic                            cfg_valid_i,
  input  logic [hmlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hmlc_pkg::THR_W-1:0]      cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hmlc_pkg::BIN_OUT_W-1:0]  mode_bin_o,
  output logic [hmlc_pkg::CNT_OUT_W-1:0]  mode_count_o,
  output logic [hmlc_pkg::CLASS_W-1:0]    level_class_o
);

  localparam int unsigned BIN_W  = $clog2(BIN_COUNT);
  localparam int unsigned PROD_W = hmlc_pkg::PIX_W + BIN_W + 1;
  localparam int unsigned SHIFT  = $clog2(hmlc_pkg::PIX_RANGE);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BIN_COUNT - 1);

  logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic [BIN_W-1:0]       bin_q, bin_in;
  logic                   last_q;
  logic [PROD_W-1:0]      prod;

  logic [BIN_W-1:0]       best_bin_q, best_bin_d;
  logic [COUNT_WIDTH-1:0] best_cnt_q, best_cnt_d;
  logic [BIN_W-1:0]       clr_idx_q, clr_idx_d;
  logic [COUNT_WIDTH-1:0] inc;

  logic                   wr_en;
  logic [BIN_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;

  logic [hmlc_pkg::THR_W-1:0] thr_q [hmlc_pkg::NUM_LEVELS];

  logic                             out_valid_q, out_valid_d;
  logic [hmlc_pkg::BIN_OUT_W-1:0]   mode_bin_q;
  logic [hmlc_pkg::CNT_OUT_W-1:0]   mode_count_q;
  logic [hmlc_pkg::CLASS_W-1:0]     level_class_q;
  logic [hmlc_pkg::BIN_OUT_W-1:0]   mode_bin_w;
  logic [hmlc_pkg::CNT_OUT_W-1:0]   mode_count_w;
  logic [hmlc_pkg::CLASS_W-1:0]     level_class_w;
  logic [31:0]                      best_ext;

  // bin index: pixel * bins / pixel range
  assign prod   = PROD_W'(pixel_value_i) * PROD_W'(BIN_COUNT);
  assign bin_in = BIN_W'(prod >> SHIFT);

  assign inc = (rd_q == CNT_MAX) ? rd_q : rd_q + 1'b1;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_idx_q;
    wr_data = '0;
    if (cmd_i.update) begin
      wr_en   = 1'b1;
      wr_addr = bin_q;
      wr_data = inc;
    end else if (cmd_i.clear_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.accept) begin
      rd_q   <= mem[bin_in];
      bin_q  <= bin_in;
      last_q <= last_pixel_i;
    end
  end

  always_comb begin
    best_bin_d = best_bin_q;
    best_cnt_d = best_cnt_q;
    if (cmd_i.load_out) begin
      best_bin_d = '0;
      best_cnt_d = '0;
    end else if (cmd_i.update) begin
      if ((inc > best_cnt_q) || ((inc == best_cnt_q) && (bin_q < best_bin_q))) begin
        best_bin_d = bin_q;
        best_cnt_d = inc;
      end
    end
  end

  always_comb begin
    clr_idx_d = clr_idx_q;
    if (cmd_i.clear_wr && !cmd_i.update) begin
      clr_idx_d = (clr_idx_q == LAST_BIN) ? '0 : clr_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_bin_q <= '0;
      best_cnt_q <= '0;
      clr_idx_q  <= '0;
    end else begin
      best_bin_q <= best_bin_d;
      best_cnt_q <= best_cnt_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hmlc_pkg::THR_RESET;
    end else if (cfg_valid_i && (32'(cfg_index_i) < hmlc_pkg::NUM_LEVELS)) begin
      thr_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign mode_bin_w = hmlc_pkg::BIN_OUT_W'(best_bin_q);
  assign best_ext   = 32'(best_cnt_q);
  assign mode_count_w = (best_ext > 32'h0000_FFFF) ? 16'hFFFF
                                                   : best_ext[hmlc_pkg::CNT_OUT_W-1:0];

  // first threshold met wins, so scan from the last level down
  always_comb begin
    level_class_w = hmlc_pkg::CLASS_W'(hmlc_pkg::NUM_LEVELS);
    for (int k = hmlc_pkg::NUM_LEVELS - 1; k >= 0; k--) begin
      if ({1'b0, mode_bin_w} >= thr_q[k]) begin
        level_class_w = hmlc_pkg::CLASS_W'(k);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mode_bin_q    <= mode_bin_w;
      mode_count_q  <= mode_count_w;
      level_class_q <= level_class_w;
    end
  end

  assign stat_o.last       = last_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.clear_done = (clr_idx_q == LAST_BIN);

  assign out_valid_o   = out_valid_q;
  assign mode_bin_o    = mode_bin_q;
  assign mode_count_o  = mode_count_q;
  assign level_class_o = level_class_q;

endmodule

@@ rtl/histogram_mode_level_classifier.sv @@
// Histogram mode classifier: pixels of one region arrive one per item, tlast on the
// final one. Each pixel's bin is read from the single-port bin memory, then its
// saturated count is written back and the mode updated before the next pixel is
// taken. After the last pixel the block waits until the previous result is claimed,
// and then the histogram is swept clear, one bin per cycle, while no pixel is taken;
// the same sweep runs after reset. The result (mode bin, its count, and its class
// from the five thresholds tested level 0 first) waits in an output register, so the
// next region may start while it is still unclaimed. Threshold writes are accepted
// every cycle and take effect on the next result.
module histogram_mode_level_classifier #(
  parameter int unsigned BIN_COUNT   = hmlc_pkg::BIN_COUNT_DEF,
  parameter int unsigned COUNT_WIDTH = hmlc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hmlc_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel_value
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hmlc_pkg::M_DATA_W-1:0]   m_axis_tdata,   // mode_bin, mode_count, level_class
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hmlc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hmlc_pkg::THR_W-1:0]      cfg_data_i
);

  hmlc_pkg::hmlc_cmd_t  cmd;
  hmlc_pkg::hmlc_stat_t stat;

  logic [hmlc_pkg::BIN_OUT_W-1:0] mode_bin;
  logic [hmlc_pkg::CNT_OUT_W-1:0] mode_count;
  logic [hmlc_pkg::CLASS_W-1:0]   level_class;

  hmlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hmlc_datapath #(
    .BIN_COUNT   (BIN_COUNT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .pixel_value_i (s_axis_tdata),
    .last_pixel_i  (s_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .mode_bin_o    (mode_bin),
    .mode_count_o  (mode_count),
    .level_class_o (level_class)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {5'b0, level_class, mode_count, mode_bin};

endmodule

@@ rtl/hmlc_checker.sv @@
module hmlc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[26:24] <= 3'd5))
    else $error("class out of range");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("item taken while previous one in update");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_acc && s_axis_tlast, 3))
    else $error("result without a last item");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("item taken before histogram clear");

endmodule

bind histogram_mode_level_classifier hmlc_checker u_hmlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
